// ----- sv/fspe_pkg.sv -----
// fspe_pkg: shared types, constants and codes of the filtered shortest path engine
// depends on: nothing
package fspe_pkg;

  // default sizes
  localparam int DEF_MAX_NODES   = 256;
  localparam int DEF_MAX_EDGES   = 1024;
  localparam int DEF_WEIGHT_BITS = 16;

  // fixed field widths
  localparam int NODE_IN_W  = 8;
  localparam int WEIGHT_IN_W = 16;
  localparam int NCFG_W     = 9;
  localparam int DIST_W     = 32;
  localparam int CFG_DATA_W = 9;

  // distance marking a node that was not reached
  localparam logic [DIST_W-1:0] UNREACH = 32'd1000000005;

  // reset values of the configuration registers
  localparam logic [NCFG_W-1:0]    RST_NODE_COUNT  = 9'd256;
  localparam logic [NODE_IN_W-1:0] RST_SOURCE_NODE = 8'd0;
  localparam logic [NODE_IN_W-1:0] RST_TARGET_NODE = 8'd255;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NODE_COUNT  = 2'd0,
    CFG_SOURCE_NODE = 2'd1,
    CFG_TARGET_NODE = 2'd2
  } cfg_idx_t;

  // request kinds
  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_RUN  = 1'b1
  } kind_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN_START,
    ST_SCAN,
    ST_SETTLE,
    ST_EFETCH,
    ST_EWAIT,
    ST_RELAX,
    ST_NEXT_PASS,
    ST_FINAL_RD,
    ST_REPORT
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_EDGE_WR,
    OP_RUN,
    OP_INIT,
    OP_SCAN_CLR,
    OP_SCAN,
    OP_SETTLE,
    OP_EDGE_RD,
    OP_EDGE_CHK,
    OP_RELAX,
    OP_NEXT_PASS,
    OP_FINAL_RD,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic src_ok;
    logic init_last;
    logic scan_done;
    logic found;
    logic edges_none;
    logic edge_more;
    logic relax_hit;
    logic last_pass;
  } sts_t;

endpackage

// ----- sv/fspe_ram.sv -----
// fspe_ram: generic single write port, single read port ram with registered read
// depends on: nothing
module fspe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fspe_ctrl.sv -----
// fspe_ctrl: sequencer of edge loads, the two shortest path passes and the report
// depends on: fspe_pkg
module fspe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_kind,
  input  fspe_pkg::sts_t sts,
  output fspe_pkg::cmd_t cmd,
  output logic           busy
);
  import fspe_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (kind_t'(in_kind) == KIND_RUN) begin
            cmd.op    = OP_RUN;
            state_nxt = sts.src_ok ? ST_INIT : ST_FINAL_RD;
          end else begin
            cmd.op = OP_EDGE_WR;
          end
        end
      end
      ST_INIT: begin
        cmd.op = OP_INIT;
        if (sts.init_last) begin
          state_nxt = ST_SCAN_START;
        end
      end
      ST_SCAN_START: begin
        cmd.op    = OP_SCAN_CLR;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.scan_done) begin
          priority if (sts.found) begin
            state_nxt = ST_SETTLE;
          end else if (sts.last_pass) begin
            state_nxt = ST_FINAL_RD;
          end else begin
            state_nxt = ST_NEXT_PASS;
          end
        end
      end
      ST_SETTLE: begin
        cmd.op    = OP_SETTLE;
        state_nxt = sts.edges_none ? ST_SCAN_START : ST_EFETCH;
      end
      ST_EFETCH: begin
        cmd.op    = OP_EDGE_RD;
        state_nxt = ST_EWAIT;
      end
      ST_EWAIT: begin
        cmd.op = OP_EDGE_CHK;
        priority if (sts.relax_hit) begin
          state_nxt = ST_RELAX;
        end else if (sts.edge_more) begin
          state_nxt = ST_EFETCH;
        end else begin
          state_nxt = ST_SCAN_START;
        end
      end
      ST_RELAX: begin
        cmd.op    = OP_RELAX;
        state_nxt = sts.edge_more ? ST_EFETCH : ST_SCAN_START;
      end
      ST_NEXT_PASS: begin
        cmd.op    = OP_NEXT_PASS;
        state_nxt = ST_INIT;
      end
      ST_FINAL_RD: begin
        cmd.op    = OP_FINAL_RD;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.op    = OP_REPORT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- sv/fspe_dpath.sv -----
// fspe_dpath: configuration, edge store, distance memories, scan and relax logic
// depends on: fspe_pkg, fspe_ram
module fspe_dpath #(
  parameter int MAX_NODES   = fspe_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = fspe_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = fspe_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fspe_pkg::cmd_t                    cmd,
  output fspe_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [fspe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [fspe_pkg::NODE_IN_W-1:0]    in_end_a,
  input  logic [fspe_pkg::NODE_IN_W-1:0]    in_end_b,
  input  logic [fspe_pkg::WEIGHT_IN_W-1:0]  in_weight,
  output logic                              out_valid,
  output logic [fspe_pkg::DIST_W-1:0]       out_distance,
  output logic                              out_reachable,
  output logic                              out_edges_dropped
);
  import fspe_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int EWD = 2 * NW + WEIGHT_BITS;
  localparam int DW  = DIST_W + 1;

  // configuration registers
  logic [NCFG_W-1:0]    node_count_r;
  logic [NODE_IN_W-1:0] source_r;
  logic [NODE_IN_W-1:0] target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= RST_NODE_COUNT;
      source_r     <= RST_SOURCE_NODE;
      target_r     <= RST_TARGET_NODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_COUNT:  node_count_r <= cfg_wdata;
        CFG_SOURCE_NODE: source_r     <= NODE_IN_W'(cfg_wdata);
        CFG_TARGET_NODE: target_r     <= NODE_IN_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // effective node count, clamped to 1 .. MAX_NODES
  logic [NCW-1:0] n_eff;
  always_comb begin
    priority if (node_count_r == '0) begin
      n_eff = NCW'(1);
    end else if (32'(node_count_r) > 32'(MAX_NODES)) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(node_count_r);
    end
  end

  logic src_ok, tgt_ok;
  assign src_ok = 32'(source_r) < 32'(n_eff);
  assign tgt_ok = 32'(target_r) < 32'(n_eff);

  // edge store and its fill count
  logic [ETW-1:0]  edge_total_r;
  logic            overflow_r;
  logic            ed_in_rng, ed_full, ed_we;
  logic [EWD-1:0]  ed_wdata, ed_rdata;
  logic [EAW-1:0]  ed_raddr;
  logic [ETW-1:0]  eidx_r;

  assign ed_in_rng = (32'(in_end_a) < 32'(n_eff)) && (32'(in_end_b) < 32'(n_eff));
  assign ed_full   = (32'(edge_total_r) >= 32'(MAX_EDGES));
  assign ed_we     = (cmd.op == OP_EDGE_WR) && ed_in_rng && !ed_full;
  assign ed_wdata  = {NW'(in_end_a), NW'(in_end_b), WEIGHT_BITS'(in_weight)};
  assign ed_raddr  = eidx_r[EAW-1:0];

  fspe_ram #(.WIDTH(EWD), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (ed_we),
    .waddr (edge_total_r[EAW-1:0]),
    .wdata (ed_wdata),
    .raddr (ed_raddr),
    .rdata (ed_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.op == OP_REPORT) begin
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
    end else if (cmd.op == OP_EDGE_WR && ed_in_rng) begin
      if (ed_full) begin
        overflow_r <= 1'b1;
      end else begin
        edge_total_r <= edge_total_r + ETW'(1);
      end
    end
  end

  // pass flag, node counter, best-node tracking
  logic                pass_r;
  logic [NCW-1:0]      idx_r;
  logic                pend_r;
  logic [NW-1:0]       rd_idx_r;
  logic [NW-1:0]       best_r;
  logic [DIST_W-1:0]   best_d_r;
  logic                found_r;
  logic [NW-1:0]       to_r;
  logic [WEIGHT_BITS-1:0] w_r;

  // distance memories: {settled, distance}; a holds pass one, b holds pass two
  logic          cur_we;
  logic [NW-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, rd_a, rd_b, cur_rd;

  fspe_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_a (
    .clk   (clk),
    .we    (cur_we && !pass_r),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (rd_a)
  );

  fspe_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_b (
    .clk   (clk),
    .we    (cur_we && pass_r),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (rd_b)
  );

  assign cur_rd = pass_r ? rd_b : rd_a;

  // fetched edge decode
  logic [NW-1:0]          e_a, e_b, to_c;
  logic [WEIGHT_BITS-1:0] e_w;
  logic                   hit_c;
  assign {e_a, e_b, e_w} = ed_rdata;
  assign hit_c = (NCW'(e_a) < n_eff) && (NCW'(e_b) < n_eff) && (e_a != e_b) &&
                 ((e_a == best_r) || (e_b == best_r));
  assign to_c  = (e_a == best_r) ? e_b : e_a;

  // saturated candidate and relax test
  logic [DIST_W:0]   sum_c;
  logic [DIST_W-1:0] cand_c;
  logic              relax_ok;
  assign sum_c    = {1'b0, best_d_r} + (DIST_W + 1)'(w_r);
  assign cand_c   = (sum_c >= (DIST_W + 1)'(UNREACH)) ? (UNREACH - DIST_W'(1))
                                                      : sum_c[DIST_W-1:0];
  assign relax_ok = (cand_c < cur_rd[DIST_W-1:0]) &&
                    (!pass_r || (cand_c > rd_a[DIST_W-1:0]));

  // distance memory port selection
  always_comb begin
    cur_we  = 1'b0;
    d_waddr = idx_r[NW-1:0];
    d_wdata = {1'b0, UNREACH};
    d_raddr = idx_r[NW-1:0];
    unique case (cmd.op)
      OP_INIT: begin
        cur_we  = 1'b1;
        d_wdata = {1'b0, (idx_r == NCW'(source_r)) ? '0 : UNREACH};
      end
      OP_SETTLE: begin
        cur_we  = 1'b1;
        d_waddr = best_r;
        d_wdata = {1'b1, best_d_r};
      end
      OP_EDGE_CHK: begin
        d_raddr = to_c;
      end
      OP_RELAX: begin
        cur_we  = relax_ok;
        d_waddr = to_r;
        d_wdata = {cur_rd[DIST_W], cand_c};
      end
      OP_FINAL_RD: begin
        d_raddr = NW'(target_r);
      end
      default: ;
    endcase
  end

  // pass and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r  <= 1'b0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
      eidx_r  <= '0;
    end else begin
      unique case (cmd.op)
        OP_RUN: begin
          pass_r <= 1'b0;
          idx_r  <= '0;
        end
        OP_NEXT_PASS: begin
          pass_r <= 1'b1;
          idx_r  <= '0;
        end
        OP_INIT: begin
          idx_r <= idx_r + NCW'(1);
        end
        OP_SCAN_CLR: begin
          idx_r    <= '0;
          pend_r   <= 1'b0;
          found_r  <= 1'b0;
          best_d_r <= UNREACH;
        end
        OP_SCAN: begin
          if (idx_r < n_eff) begin
            idx_r    <= idx_r + NCW'(1);
            rd_idx_r <= idx_r[NW-1:0];
            pend_r   <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          // strict compare keeps the lowest index on ties
          if (pend_r && !cur_rd[DIST_W] && (cur_rd[DIST_W-1:0] < best_d_r)) begin
            best_d_r <= cur_rd[DIST_W-1:0];
            best_r   <= rd_idx_r;
            found_r  <= 1'b1;
          end
        end
        OP_SETTLE: begin
          eidx_r <= '0;
        end
        OP_EDGE_RD: begin
          eidx_r <= eidx_r + ETW'(1);
        end
        OP_EDGE_CHK: begin
          to_r <= to_c;
          w_r  <= e_w;
        end
        default: ;
      endcase
    end
  end

  // result register, strobed for one cycle
  logic [DIST_W-1:0] fin_d;
  logic              fin_reach;
  assign fin_d     = rd_b[DIST_W-1:0];
  assign fin_reach = src_ok && tgt_ok && (fin_d != UNREACH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (cmd.op == OP_REPORT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_REPORT) begin
      out_distance      <= fin_reach ? fin_d : '0;
      out_reachable     <= fin_reach;
      out_edges_dropped <= overflow_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.src_ok     = src_ok;
    sts.init_last  = ((idx_r + NCW'(1)) == n_eff);
    sts.scan_done  = (idx_r == n_eff) && !pend_r;
    sts.found      = found_r;
    sts.edges_none = (edge_total_r == '0);
    sts.edge_more  = (eidx_r < edge_total_r);
    sts.relax_hit  = hit_c;
    sts.last_pass  = pass_r;
  end

endmodule

// ----- sv/filtered_shortest_path_engine_core.sv -----
// filtered_shortest_path_engine_core: top level, controller plus datapath
// depends on: fspe_pkg, fspe_ctrl, fspe_dpath, fspe_ram
//
//  channel   ports                                   handshake
//  request   in_kind in_end_a in_end_b in_weight     start high, busy low
//  result    out_distance out_reachable              out_valid, one cycle
//            out_edges_dropped
//  config    cfg_index cfg_wdata                     cfg_we, no wait
//
// edge request: busy stays low; a run holds busy for both passes and the report
// (no passes if the source is out of range); per pass: init of each node, then per
// settled node a scan of all nodes, a settle step, a fetch and check of each stored
// edge and a relax step if it touches that node, then a final scan; a step between
// passes, then final read and report; the single read port of each distance memory
// paces the scans; reset is synchronous active low; results cannot be stalled
module filtered_shortest_path_engine_core #(
  parameter int MAX_NODES   = fspe_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = fspe_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = fspe_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_kind,
  input  logic [fspe_pkg::NODE_IN_W-1:0]    in_end_a,
  input  logic [fspe_pkg::NODE_IN_W-1:0]    in_end_b,
  input  logic [fspe_pkg::WEIGHT_IN_W-1:0]  in_weight,
  output logic                              out_valid,
  output logic [fspe_pkg::DIST_W-1:0]       out_distance,
  output logic                              out_reachable,
  output logic                              out_edges_dropped,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [fspe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fspe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  fspe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // datapath
  fspe_dpath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_end_a          (in_end_a),
    .in_end_b          (in_end_b),
    .in_weight         (in_weight),
    .out_valid         (out_valid),
    .out_distance      (out_distance),
    .out_reachable     (out_reachable),
    .out_edges_dropped (out_edges_dropped)
  );

endmodule

// ----- sv/fspe_checker.sv -----
// fspe_checker: port level assertions of the engine, bound to the top level
// depends on: fspe_pkg, filtered_shortest_path_engine_core
module fspe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic [fspe_pkg::DIST_W-1:0]       out_distance,
  input logic                              out_reachable
);
  import fspe_pkg::*;

  // a run request makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind) |=> busy)
    else $error("run request did not raise busy");

  // results come one at a time, never on adjacent cycles
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result appears once the run is over
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

  // unreachable targets report zero distance
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reachable) |-> (out_distance == '0))
    else $error("nonzero distance for unreachable target");

  // reported distances stay below the sentinel
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance < UNREACH))
    else $error("distance not saturated");

endmodule

bind filtered_shortest_path_engine_core fspe_checker u_fspe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_distance  (out_distance),
  .out_reachable (out_reachable)
);
